/* rtl/nru_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the NRU victim selector.
package nru_pkg;

  // Frame store geometry
  localparam int FRAMES = 128;
  localparam int IDX_W  = $clog2(FRAMES);
  localparam int CNT_W  = $clog2(FRAMES + 1);

  // Field and register widths
  localparam int ACT_W    = 2;
  localparam int FRAME_W  = 7;
  localparam int ICOUNT_W = 32;
  localparam int FC_W     = 8;
  localparam int RI_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 10;
  localparam int CLS_W    = 2;

  // Register reset values
  localparam logic [FC_W-1:0] FC_RESET = FC_W'(128);
  localparam logic [RI_W-1:0] RI_RESET = RI_W'(50);

  // Action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_ACCESS = 2'd0,
    ACT_MAP    = 2'd1,
    ACT_SELECT = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_COUNT    = 2'd0,
    REG_RESET_INTERVAL = 2'd1,
    REG_SPARE2         = 2'd2,
    REG_SPARE3         = 2'd3
  } cfg_reg_t;

  // Class code of a clean, unreferenced frame
  localparam logic [CLS_W-1:0] CLS_FREE = 2'd0;

endpackage

/* rtl/nru_page_victim_selector.sv */
`timescale 1ns / 1ps
// Not-recently-used frame replacement: bit tracking, victim scan, periodic clear.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid/in_stall, action, frame, is_write, cnt | in
//  result  | out_valid/out_stall, victim_frame/class, clear  | out
//  config  | cfg_we, cfg_index, cfg_wdata                    | in
//
// Access and map update the bits when accepted and give no result. A select
// passes through ST_WRAP, ST_SCAN and ST_FIN: w hand-wrap subtractions (nonzero only after frame_count
// shrinks below the hand), then s frames scanned one per cycle through the single
// class compare (s at most the frames in use). Reset clears all bits at once.
// A finished result waits in the output register; the final state of the
// next select holds while that register is still stalled.
module nru_page_victim_selector (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [nru_pkg::ACT_W-1:0]      in_action,
  input  logic [nru_pkg::FRAME_W-1:0]    in_frame,
  input  logic                           in_is_write,
  input  logic [nru_pkg::ICOUNT_W-1:0]   in_instr_count,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [nru_pkg::FRAME_W-1:0]    out_victim_frame,
  output logic [nru_pkg::CLS_W-1:0]      out_victim_class,
  output logic                           out_ref_cleared,
  // configuration
  input  logic                           cfg_we,
  input  logic [nru_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nru_pkg::CFG_W-1:0]      cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRAP,
    ST_SCAN,
    ST_FIN
  } state_t;

  localparam int IDX_W = nru_pkg::IDX_W;
  localparam int CNT_W = nru_pkg::CNT_W;
  localparam int LC_W  = nru_pkg::ICOUNT_W + 1;
  localparam int DF_W  = nru_pkg::ICOUNT_W + 2;

  state_t                         state_r, state_nxt;
  logic [nru_pkg::FRAMES-1:0]     ref_r, ref_nxt;
  logic [nru_pkg::FRAMES-1:0]     mod_r, mod_nxt;
  logic [IDX_W-1:0]               hand_r, hand_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt;
  logic [IDX_W-1:0]               best_frame_r, best_frame_nxt;
  logic [nru_pkg::CLS_W-1:0]      best_cls_r, best_cls_nxt;
  logic                           best_vld_r, best_vld_nxt;
  logic [nru_pkg::ICOUNT_W-1:0]   icount_r, icount_nxt;
  logic [LC_W-1:0]                last_clr_r, last_clr_nxt;
  logic [nru_pkg::FC_W-1:0]       fc_r, fc_nxt;
  logic [nru_pkg::RI_W-1:0]       ri_r, ri_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [nru_pkg::FRAME_W-1:0]    out_frame_r, out_frame_nxt;
  logic [nru_pkg::CLS_W-1:0]      out_cls_r, out_cls_nxt;
  logic                           out_clr_r, out_clr_nxt;

  logic [CNT_W-1:0]               n_act;
  logic [nru_pkg::CLS_W-1:0]      cls;
  logic [CNT_W-1:0]               idx_inc;
  logic [CNT_W-1:0]               best_inc;
  logic [DF_W-1:0]                diff;
  logic                           do_clear;
  logic                           in_xfer;

  // Frames in use: zero counts as one, saturate at the store size
  always_comb begin
    if (fc_r == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(fc_r) > nru_pkg::FRAMES) begin
      n_act = CNT_W'(nru_pkg::FRAMES);
    end else begin
      n_act = CNT_W'(fc_r);
    end
  end

  // Shared class compare and index step
  assign cls      = {ref_r[idx_r], mod_r[idx_r]};
  assign idx_inc  = CNT_W'(idx_r) + CNT_W'(1);
  assign best_inc = CNT_W'(best_frame_r) + CNT_W'(1);

  // Signed distance since the last clear; last_clr_r may be minus one
  assign diff     = {2'b00, icount_r} - {last_clr_r[LC_W-1], last_clr_r};
  assign do_clear = !diff[DF_W-1] && (diff[DF_W-2:0] >= (DF_W-1)'(ri_r));

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // Next-state logic
  always_comb begin
    state_nxt      = state_r;
    ref_nxt        = ref_r;
    mod_nxt        = mod_r;
    hand_nxt       = hand_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    best_frame_nxt = best_frame_r;
    best_cls_nxt   = best_cls_r;
    best_vld_nxt   = best_vld_r;
    icount_nxt     = icount_r;
    last_clr_nxt   = last_clr_r;
    fc_nxt         = fc_r;
    ri_nxt         = ri_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_frame_nxt  = out_frame_r;
    out_cls_nxt    = out_cls_r;
    out_clr_nxt    = out_clr_r;

    // config writes
    if (cfg_we) begin
      unique case (cfg_index)
        nru_pkg::REG_FRAME_COUNT:    fc_nxt = cfg_wdata[nru_pkg::FC_W-1:0];
        nru_pkg::REG_RESET_INTERVAL: ri_nxt = cfg_wdata[nru_pkg::RI_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (in_action)
            nru_pkg::ACT_ACCESS: begin
              ref_nxt[IDX_W'(in_frame)] = 1'b1;
              if (in_is_write) begin
                mod_nxt[IDX_W'(in_frame)] = 1'b1;
              end
            end
            nru_pkg::ACT_MAP: begin
              ref_nxt[IDX_W'(in_frame)] = 1'b0;
              mod_nxt[IDX_W'(in_frame)] = 1'b0;
            end
            nru_pkg::ACT_SELECT: begin
              icount_nxt   = in_instr_count;
              idx_nxt      = hand_r;
              best_vld_nxt = 1'b0;
              state_nxt    = ST_WRAP;
            end
            default: ;
          endcase
        end
      end

      // hand mod frame count, one subtraction a cycle
      ST_WRAP: begin
        if (CNT_W'(idx_r) >= n_act) begin
          idx_nxt = idx_r - IDX_W'(n_act);
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end

      // one frame per cycle; stop at the first free frame
      ST_SCAN: begin
        if (cls == nru_pkg::CLS_FREE) begin
          best_frame_nxt = idx_r;
          best_cls_nxt   = cls;
          best_vld_nxt   = 1'b1;
          state_nxt      = ST_FIN;
        end else begin
          if (!best_vld_r || cls < best_cls_r) begin
            best_frame_nxt = idx_r;
            best_cls_nxt   = cls;
            best_vld_nxt   = 1'b1;
          end
          if (cnt_r == n_act - CNT_W'(1)) begin
            state_nxt = ST_FIN;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
            idx_nxt = (idx_inc == n_act) ? '0 : IDX_W'(idx_inc);
          end
        end
      end

      // advance hand, periodic clear, load result
      ST_FIN: begin
        if (!(out_valid_r && out_stall)) begin
          hand_nxt      = (best_inc == n_act) ? '0 : IDX_W'(best_inc);
          out_valid_nxt = 1'b1;
          out_frame_nxt = nru_pkg::FRAME_W'(best_frame_r);
          out_cls_nxt   = best_cls_r;
          out_clr_nxt   = do_clear;
          if (do_clear) begin
            last_clr_nxt = {1'b0, icount_r};
            for (int i = 0; i < nru_pkg::FRAMES; i++) begin
              if (CNT_W'(i) < n_act) begin
                ref_nxt[i] = 1'b0;
              end
            end
          end
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ref_r       <= '0;
      mod_r       <= '0;
      hand_r      <= '0;
      last_clr_r  <= '1;
      fc_r        <= nru_pkg::FC_RESET;
      ri_r        <= nru_pkg::RI_RESET;
      out_valid_r <= 1'b0;
      best_vld_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ref_r       <= ref_nxt;
      mod_r       <= mod_nxt;
      hand_r      <= hand_nxt;
      last_clr_r  <= last_clr_nxt;
      fc_r        <= fc_nxt;
      ri_r        <= ri_nxt;
      out_valid_r <= out_valid_nxt;
      best_vld_r  <= best_vld_nxt;
    end
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    best_frame_r <= best_frame_nxt;
    best_cls_r   <= best_cls_nxt;
    icount_r     <= icount_nxt;
    out_frame_r  <= out_frame_nxt;
    out_cls_r    <= out_cls_nxt;
    out_clr_r    <= out_clr_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_victim_frame = out_frame_r;
  assign out_victim_class = out_cls_r;
  assign out_ref_cleared  = out_clr_r;

endmodule
